/* src/tcg_pkg.sv */
package tcg_pkg;

	localparam logic [1:0] OP_FONT   = 2'd0;
	localparam logic [1:0] OP_CURSOR = 2'd1;
	localparam logic [1:0] OP_CHAR   = 2'd2;

	localparam logic [7:0] CHAR_CR = 8'd13;
	localparam logic [7:0] CHAR_LF = 8'd10;

	localparam logic [1:0] COL_8  = 2'd0;
	localparam logic [1:0] COL_16 = 2'd1;
	localparam logic [1:0] COL_24 = 2'd2;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_MODE   = 2'd2;

	localparam logic [12:0] WIDTH_RESET  = 13'd640;
	localparam logic [12:0] HEIGHT_RESET = 13'd480;
	localparam logic [1:0]  MODE_RESET   = COL_16;

	typedef struct packed {
		logic [12:0] screen_width;
		logic [12:0] screen_height;
		logic [1:0]  colour_mode;
	} tcg_cfg_t;

	typedef struct packed {
		logic [11:0] pixel_x;
		logic [12:0] row_y;
		logic [23:0] draw_colour;
		logic        last_row;
	} tcg_meta_t;

	typedef struct packed {
		tcg_meta_t  meta;
		logic [7:0] row_mask;
	} tcg_word_t;

endpackage

/* src/tcg_ram.sv */
module tcg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* src/tcg_ctrl.sv */
module tcg_ctrl
	import tcg_pkg::*;
#(
	parameter int FONT_CHARS = 256,
	parameter int GLYPH_ROWS = 16,
	parameter int COORD_BITS = 12
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              opcode,
	input  logic [11:0]             font_address,
	input  logic [7:0]              font_byte,
	input  logic [11:0]             start_x,
	input  logic [11:0]             start_y,
	input  logic [7:0]              char_code,
	input  logic [23:0]             colour,
	input  tcg_cfg_t                cfg,
	input  logic                    space_ok,
	output logic                    ram_we,
	output logic [$clog2(FONT_CHARS*GLYPH_ROWS)-1:0] ram_waddr,
	output logic [7:0]              ram_wdata,
	output logic                    ram_re,
	output logic [$clog2(FONT_CHARS*GLYPH_ROWS)-1:0] ram_raddr,
	output logic                    rd_valid_s1,
	output tcg_meta_t               meta_s1
);

	localparam int DEPTH = FONT_CHARS * GLYPH_ROWS;
	localparam int AW    = $clog2(DEPTH);
	localparam int CB    = (FONT_CHARS > 1) ? $clog2(FONT_CHARS) : 1;
	localparam int RW    = $clog2(GLYPH_ROWS);
	localparam int CW    = COORD_BITS + 1;
	localparam int PXW   = (COORD_BITS < 12) ? COORD_BITS : 12;
	localparam int LW    = ((CW > 13) ? CW : 13) + 2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RENDER,
		ST_WRAP
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   cur_x_q;
	logic [CW-1:0]   cur_y_q;
	logic [RW-1:0]   row_q;
	logic [AW-1:0]   base_q;
	logic [23:0]     colour_q;

	logic [CB-1:0]   char_mod [256];
	logic            accept;
	logic            issue;
	logic [23:0]     colour_masked;
	logic signed [LW-1:0] xs, xl, ys, yl;
	logic            x_wrap;
	logic            y_wrap;
	logic [CW-1:0]   y_after_x;

	for (genvar i = 0; i < 256; i++) begin : g_mod
		assign char_mod[i] = CB'(i % FONT_CHARS);
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign issue     = (state_q == ST_RENDER) && space_ok;

	assign ram_we    = accept && (opcode == OP_FONT) && (32'(font_address) < DEPTH);
	assign ram_waddr = AW'(font_address);
	assign ram_wdata = font_byte;
	assign ram_re    = issue;
	assign ram_raddr = AW'(base_q + AW'(row_q));

	always_comb begin
		case (cfg.colour_mode)
			COL_8:   colour_masked = {16'd0, colour[7:0]};
			COL_16:  colour_masked = {8'd0, colour[15:0]};
			default: colour_masked = colour;
		endcase
	end

	assign xs        = LW'(cur_x_q);
	assign xl        = LW'(cfg.screen_width) - LW'(8);
	assign x_wrap    = (xs >= xl);
	assign y_after_x = x_wrap ? CW'(cur_y_q + CW'(GLYPH_ROWS)) : cur_y_q;
	assign ys        = LW'(y_after_x);
	assign yl        = LW'(cfg.screen_height) - LW'(8);
	assign y_wrap    = (ys >= yl);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			row_q       <= '0;
			base_q      <= '0;
			colour_q    <= '0;
			rd_valid_s1 <= 1'b0;
			meta_s1     <= '0;
		end else begin
			rd_valid_s1 <= issue;
			if (issue) begin
				meta_s1.pixel_x     <= 12'(cur_x_q[PXW-1:0]);
				meta_s1.row_y       <= 13'(CW'(cur_y_q + CW'(row_q)));
				meta_s1.draw_colour <= colour_q;
				meta_s1.last_row    <= (row_q == RW'(GLYPH_ROWS - 1));
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (opcode)
							OP_CURSOR: begin
								cur_x_q <= CW'(start_x);
								cur_y_q <= CW'(start_y);
							end
							OP_CHAR: begin
								colour_q <= colour_masked;
								if (char_code == CHAR_CR) begin
									cur_x_q <= '0;
									state_q <= ST_WRAP;
								end else if (char_code == CHAR_LF) begin
									cur_y_q <= CW'(cur_y_q + CW'(GLYPH_ROWS));
									state_q <= ST_WRAP;
								end else begin
									base_q  <= AW'(char_mod[char_code] * GLYPH_ROWS);
									row_q   <= '0;
									state_q <= ST_RENDER;
								end
							end
							default: ;
						endcase
					end
				end
				ST_RENDER: begin
					if (issue) begin
						row_q <= RW'(row_q + RW'(1));
						if (row_q == RW'(GLYPH_ROWS - 1)) begin
							cur_x_q <= CW'(cur_x_q + CW'(8));
							state_q <= ST_WRAP;
						end
					end
				end
				ST_WRAP: begin
					cur_x_q <= (x_wrap || y_wrap) ? '0 : cur_x_q;
					cur_y_q <= y_wrap ? '0 : y_after_x;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* src/tcg_out.sv */
module tcg_out
	import tcg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  tcg_meta_t   meta,
	input  logic [7:0]  rdata,
	output logic        space_ok,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,
	output logic        m_tlast
);

	tcg_word_t  buf_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;
	logic [2:0] occ;
	tcg_word_t  head;

	assign m_tvalid = (count_q != 2'd0);
	assign pop      = m_tvalid && m_tready;
	assign occ      = 3'(count_q) + 3'(push) - 3'(pop);
	assign space_ok = (occ <= 3'd1);
	assign head     = buf_q[rd_ptr_q];
	assign m_tdata  = {7'd0, head.meta.draw_colour, head.row_mask,
		head.meta.row_y, head.meta.pixel_x};
	assign m_tlast  = head.meta.last_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= 2'(occ);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= '{meta: meta, row_mask: rdata};
		end
	end

endmodule

/* src/text_cursor_glyph_renderer.sv */
// Channel  | Dir | Word contents (lowest bits first)
// s_*      | in  | tuser: opcode; tdata: font_address, font_byte, start_x, start_y,
//          |     |        char_code, colour
// m_*      | out | tdata: pixel_x, row_y, row_mask, draw_colour; tlast: last_row
// cfg_*    | in  | cfg_index selects screen_width, screen_height, colour_mode
//
// Font write and set cursor stay idle; carriage return and line feed pass the wrap state.
// A glyph character reads one font row per cycle, while the output buffer has space,
// through the single read port of the font RAM, then the wrap state applies the wrap.
// Reset clears the cursor and loads 640 x 480, 16-bit colour; the font RAM is not cleared.
// A stalled m_tready holds the row reads; a two-word output buffer keeps the stream full.
module text_cursor_glyph_renderer
	import tcg_pkg::*;
#(
	parameter int FONT_CHARS = 256,
	parameter int GLYPH_ROWS = 16,
	parameter int COORD_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,  // font_address, font_byte, start_x, start_y, char_code, colour
	input  logic [1:0]  s_tuser,  // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // pixel_x, row_y, row_mask, draw_colour
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data
);

	localparam int AW = $clog2(FONT_CHARS * GLYPH_ROWS);

	tcg_cfg_t        cfg_q;
	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [7:0]      ram_wdata;
	logic            ram_re;
	logic [AW-1:0]   ram_raddr;
	logic [7:0]      ram_rdata;
	logic            rd_valid_s1;
	tcg_meta_t       meta_s1;
	logic            space_ok;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width  <= WIDTH_RESET;
			cfg_q.screen_height <= HEIGHT_RESET;
			cfg_q.colour_mode   <= MODE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_WIDTH:  cfg_q.screen_width  <= cfg_data;
				REG_HEIGHT: cfg_q.screen_height <= cfg_data;
				REG_MODE:   cfg_q.colour_mode   <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	tcg_ctrl #(
		.FONT_CHARS(FONT_CHARS),
		.GLYPH_ROWS(GLYPH_ROWS),
		.COORD_BITS(COORD_BITS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.opcode       (s_tuser),
		.font_address (s_tdata[11:0]),
		.font_byte    (s_tdata[19:12]),
		.start_x      (s_tdata[31:20]),
		.start_y      (s_tdata[43:32]),
		.char_code    (s_tdata[51:44]),
		.colour       (s_tdata[75:52]),
		.cfg          (cfg_q),
		.space_ok     (space_ok),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_re       (ram_re),
		.ram_raddr    (ram_raddr),
		.rd_valid_s1  (rd_valid_s1),
		.meta_s1      (meta_s1)
	);

	tcg_ram #(
		.WIDTH(8),
		.DEPTH(FONT_CHARS * GLYPH_ROWS)
	) u_font (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	tcg_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (rd_valid_s1),
		.meta     (meta_s1),
		.rdata    (ram_rdata),
		.space_ok (space_ok),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

/* src/tcg_checker.sv */
module tcg_checker #(
	parameter int GLYPH_ROWS = 16
) (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic        m_tlast
);

	logic        in_glyph_q;
	logic [11:0] px_q;
	logic [23:0] col_q;
	logic [5:0]  cnt_q;
	logic        m_acc;

	assign m_acc = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_glyph_q <= 1'b0;
			px_q       <= '0;
			col_q      <= '0;
			cnt_q      <= '0;
		end else if (m_acc) begin
			in_glyph_q <= !m_tlast;
			px_q       <= m_tdata[11:0];
			col_q      <= m_tdata[56:33];
			cnt_q      <= m_tlast ? 6'd0 : 6'(cnt_q + 6'd1);
		end
	end

	a_idle_in_reset: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("output word valid during reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled output word changed");

	a_row_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (cnt_q == 6'(GLYPH_ROWS - 1))))
		else $error("glyph row count and last flag disagree");

	a_same_glyph: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && in_glyph_q |-> (m_tdata[11:0] == px_q) && (m_tdata[56:33] == col_q))
		else $error("rows of one glyph differ in x or colour");

endmodule

bind text_cursor_glyph_renderer tcg_checker #(.GLYPH_ROWS(GLYPH_ROWS)) u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

/* tb/text_cursor_glyph_renderer_tb.sv */
module text_cursor_glyph_renderer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tcg_pkg::*;

	localparam realtime     CLK_PERIOD = 8.0;
	localparam int          CYCLE_LIMIT = 200000;
	localparam int          GLYPH_ROWS = 16;
	localparam int          CELL_W = 8;
	localparam int          SETTLE = 40;
	localparam logic [1:0]  OP_SPARE = 2'd3;
	localparam logic [1:0]  COL_SPARE = 2'd3;

	// s_tdata word, lowest field last
	typedef struct packed {
		logic [3:0]  pad;
		logic [23:0] colour;
		logic [7:0]  char_code;
		logic [11:0] start_y;
		logic [11:0] start_x;
		logic [7:0]  font_byte;
		logic [11:0] font_address;
	} glyph_in_t;

	// m_tdata word, lowest field last
	typedef struct packed {
		logic [6:0]  pad;
		logic [23:0] draw_colour;
		logic [7:0]  row_mask;
		logic [12:0] row_y;
		logic [11:0] pixel_x;
	} glyph_out_t;

	typedef struct packed {
		logic [11:0] px;
		logic [12:0] ry;
		logic [7:0]  mask;
		logic [23:0] dcol;
		logic        last;
	} row_exp_t;

	typedef struct {
		logic [1:0]  op;
		logic [11:0] addr;
		logic [7:0]  fbyte;
		logic [11:0] sx;
		logic [11:0] sy;
		logic [7:0]  code;
		logic [23:0] colour;
		bit          typed;
		logic [11:0] px;
		logic [12:0] ry;
		logic [7:0]  mask;
		logic [23:0] dcol;
	} script_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [79:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [12:0] cfg_data;

	logic [7:0]  font_img [4096];
	logic [15:0] rows_known [256];
	bit          listed [256];
	logic [7:0]  ready_codes [$];
	logic [12:0] cur_x;
	logic [12:0] cur_y;
	logic [12:0] scr_w;
	logic [12:0] scr_h;
	logic [1:0]  scr_mode;
	row_exp_t    rows_due [$];
	int          mismatches;
	int          cycles;
	bit          calm;
	bit          first_load;
	script_row_t script [25];

	text_cursor_glyph_renderer dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("text_cursor_glyph_renderer_tb failed");
			$finish;
		end
	end

	always @(posedge clk) m_tready <= calm || ($urandom_range(99) >= 26);

	task automatic flag_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		$display("mismatch %s: expected %0h got %0h", what, want, got);
		mismatches++;
	endtask

	always @(posedge clk) begin : row_check
		glyph_out_t got;
		row_exp_t   want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (rows_due.size() == 0) begin
				flag_mismatch("unexpected word pixel_x", '0, 32'(got.pixel_x));
			end else begin
				want = rows_due.pop_front();
				if (got.pixel_x !== want.px)
					flag_mismatch("pixel_x", 32'(want.px), 32'(got.pixel_x));
				if (got.row_y !== want.ry)
					flag_mismatch("row_y", 32'(want.ry), 32'(got.row_y));
				if (got.row_mask !== want.mask)
					flag_mismatch("row_mask", 32'(want.mask), 32'(got.row_mask));
				if (got.draw_colour !== want.dcol)
					flag_mismatch("draw_colour", 32'(want.dcol), 32'(got.draw_colour));
				if (m_tlast !== want.last)
					flag_mismatch("last_row", 32'(want.last), 32'(m_tlast));
				if (got.pad !== '0) flag_mismatch("tdata pad", '0, 32'(got.pad));
			end
		end
	end

	task automatic predict_glyph_rows(input logic [1:0] op, input glyph_in_t w);
		logic [23:0] col;
		row_exp_t    e;
		logic [7:0]  code;
		case (op)
			OP_FONT: begin
				code = w.font_address[11:4];
				font_img[w.font_address] = w.font_byte;
				rows_known[code][w.font_address[3:0]] = 1'b1;
				if (&rows_known[code] && !listed[code]) begin
					listed[code] = 1'b1;
					ready_codes.push_back(code);
				end
			end
			OP_CURSOR: begin
				cur_x = {1'b0, w.start_x};
				cur_y = {1'b0, w.start_y};
			end
			OP_CHAR: begin
				case (scr_mode)
					COL_8: col = w.colour & 24'h0000FF;
					COL_16: col = w.colour & 24'h00FFFF;
					default: col = w.colour;
				endcase
				if (w.char_code == CHAR_CR) begin
					cur_x = '0;
				end else if (w.char_code == CHAR_LF) begin
					cur_y = cur_y + 13'(GLYPH_ROWS);
				end else begin
					for (int r = 0; r < GLYPH_ROWS; r++) begin
						e.px = cur_x[11:0];
						e.ry = cur_y + 13'(r);
						e.mask = font_img[{w.char_code, 4'(r)}];
						e.dcol = col;
						e.last = (r == GLYPH_ROWS - 1);
						rows_due.push_back(e);
					end
					cur_x = cur_x + 13'(CELL_W);
				end
				if (int'(cur_x) >= int'(scr_w) - CELL_W) begin
					cur_x = '0;
					cur_y = cur_y + 13'(GLYPH_ROWS);
				end
				if (int'(cur_y) >= int'(scr_h) - CELL_W) begin
					cur_y = '0;
					cur_x = '0;
				end
			end
			default: ;
		endcase
	endtask

	task automatic send_word(input logic [1:0] op, input glyph_in_t w, input bit typed,
			input row_exp_t first_row);
		int n0;
		while (!calm && $urandom_range(99) < 26) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tuser <= op;
		s_tdata <= w;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		n0 = rows_due.size();
		predict_glyph_rows(op, w);
		if (typed) rows_due[n0] = first_row;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_WIDTH: scr_w = val;
			REG_HEIGHT: scr_h = val;
			REG_MODE: scr_mode = val[1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		while (rows_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_screen(input logic [12:0] w, input logic [12:0] h,
			input logic [1:0] mode);
		drain();
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_MODE, mode);
	endtask

	function automatic glyph_in_t noise_word();
		logic [95:0] r;
		glyph_in_t   w;
		r = {$urandom, $urandom, $urandom};
		w = r[79:0];
		w.pad = '0;
		return w;
	endfunction

	function automatic logic [11:0] near_edge(input logic [12:0] limit);
		int v;
		v = int'(limit) - 2 * CELL_W + $urandom_range(2 * CELL_W);
		if (v < 0) v = 0;
		if (v > 4095) v = 4095;
		return 12'(v);
	endfunction

	task automatic run_phase(input int quota);
		int        taken;
		int        pick;
		glyph_in_t w;
		logic [7:0] code;
		taken = 0;
		while (taken < quota) begin
			w = noise_word();
			pick = $urandom_range(99);
			if (ready_codes.size() == 0 || pick < 12) begin
				code = first_load ? 8'd0 : 8'($urandom_range(255));
				first_load = 1'b0;
				for (int g = 0; g < GLYPH_ROWS; g++) begin
					w = noise_word();
					w.font_address = {code, 4'(g)};
					if ($urandom_range(7) == 0) w.font_byte = 8'hFF;
					send_word(OP_FONT, w, 1'b0, '0);
				end
				taken += GLYPH_ROWS;
			end else if (pick < 20) begin
				send_word(OP_FONT, w, 1'b0, '0);
				taken++;
			end else if (pick < 30) begin
				if ($urandom_range(1)) w.start_x = near_edge(scr_w);
				if ($urandom_range(1)) w.start_y = near_edge(scr_h);
				send_word(OP_CURSOR, w, 1'b0, '0);
				taken++;
			end else if (pick < 34) begin
				send_word(OP_SPARE, w, 1'b0, '0);
			end else if (pick < 42) begin
				w.char_code = $urandom_range(1) ? CHAR_CR : CHAR_LF;
				send_word(OP_CHAR, w, 1'b0, '0);
				taken++;
			end else begin
				w.char_code = ready_codes[$urandom_range(ready_codes.size() - 1)];
				if ($urandom_range(9) == 0) w.colour = 24'hFFFFFF;
				send_word(OP_CHAR, w, 1'b0, '0);
				taken++;
			end
		end
	endtask

	initial begin
		glyph_in_t w;
		row_exp_t  first_row;
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mismatches = 0;
		cycles = 0;
		calm = 1'b0;
		first_load = 1'b1;
		cur_x = '0;
		cur_y = '0;
		scr_w = WIDTH_RESET;
		scr_h = HEIGHT_RESET;
		scr_mode = MODE_RESET;
		for (int i = 0; i < 256; i++) begin
			rows_known[i] = '0;
			listed[i] = 1'b0;
		end

		script = '{
			'{OP_FONT, 12'hFF0, 8'hFF, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{OP_FONT, 12'hFF1, 8'h81, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{OP_FONT, 12'hFF2, 8'h42, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{OP_FONT, 12'hFF3, 8'h24, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{OP_FONT, 12'hFF4, 8'h18, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{OP_FONT, 12'hFF5, 8'h18, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{OP_FONT, 12'hFF6, 8'h24, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{OP_FONT, 12'hFF7, 8'h42, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{OP_FONT, 12'hFF8, 8'h81, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{OP_FONT, 12'hFF9, 8'hAA, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{OP_FONT, 12'hFFA, 8'h55, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{OP_FONT, 12'hFFB, 8'hF0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{OP_FONT, 12'hFFC, 8'h0F, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{OP_FONT, 12'hFFD, 8'h3C, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{OP_FONT, 12'hFFE, 8'hC3, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{OP_FONT, 12'hFFF, 8'h00, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{OP_SPARE, 12'hFFF, 8'hFF, 12'hFFF, 12'hFFF, 8'hFF, 24'hFFFFFF,
				0, 0, 0, 0, 0},
			'{OP_CHAR, 0, 0, 0, 0, 8'hFF, 24'hFFFFFF, 1, 12'd0, 13'd0, 8'hFF, 24'h00FFFF},
			'{OP_CHAR, 0, 0, 0, 0, CHAR_CR, 24'h000000, 0, 0, 0, 0, 0},
			'{OP_CHAR, 0, 0, 0, 0, CHAR_LF, 24'h000000, 0, 0, 0, 0, 0},
			'{OP_CHAR, 0, 0, 0, 0, 8'hFF, 24'h000000, 1, 12'd0, 13'd16, 8'hFF, 24'h000000},
			'{OP_CURSOR, 0, 0, 12'd4095, 12'd4095, 0, 0, 0, 0, 0, 0, 0},
			'{OP_CHAR, 0, 0, 0, 0, 8'hFF, 24'h123456, 1, 12'd4095, 13'd4095, 8'hFF,
				24'h003456},
			'{OP_CURSOR, 0, 0, 12'd624, 12'd456, 0, 0, 0, 0, 0, 0, 0},
			'{OP_CHAR, 0, 0, 0, 0, 8'hFF, 24'hABCDEF, 1, 12'd624, 13'd456, 8'hFF,
				24'h00CDEF}
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			w = '0;
			w.font_address = script[i].addr;
			w.font_byte = script[i].fbyte;
			w.start_x = script[i].sx;
			w.start_y = script[i].sy;
			w.char_code = script[i].code;
			w.colour = script[i].colour;
			first_row = '{script[i].px, script[i].ry, script[i].mask, script[i].dcol, 1'b0};
			send_word(script[i].op, w, script[i].typed, first_row);
		end

		set_screen(13'd16, 13'd16, COL_8);
		run_phase(50);
		set_screen(13'd4096, 13'd4096, COL_24);
		run_phase(50);
		set_screen(13'($urandom_range(16, 4096)), 13'($urandom_range(16, 4096)), COL_16);
		calm = 1'b1;
		run_phase(50);
		calm = 1'b0;
		set_screen(13'($urandom_range(16, 4096)), 13'($urandom_range(16, 4096)), COL_SPARE);
		run_phase(50);
		set_screen(13'($urandom_range(16, 1024)), 13'($urandom_range(16, 1024)),
			2'($urandom_range(2)));
		run_phase(50);

		drain();
		if (mismatches == 0) begin
			$display("text_cursor_glyph_renderer_tb passed");
		end else begin
			$display("text_cursor_glyph_renderer_tb failed");
		end
		$finish;
	end

endmodule
